// ===== hw/rtl/lsfp_pkg.sv =====
// Shared types and constants for the LED sequence fade player.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package lsfp_pkg;

   localparam int CHANNELS_DEF    = 4;
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int CSR_WIDTH       = 16;

   // request codes
   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_WRITE = 3'd1;
   localparam logic [2:0] REQ_START = 3'd2;
   localparam logic [2:0] REQ_FADE  = 3'd3;
   localparam logic [2:0] REQ_SLEEP = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_BASE_STEP   = 3'd0;
   localparam logic [2:0] CSR_FADE_MS     = 3'd1;
   localparam logic [2:0] CSR_SLEEP_TO    = 3'd2;
   localparam logic [2:0] CSR_CHAN_COUNT  = 3'd3;
   localparam logic [2:0] CSR_CHAN_MODES  = 3'd4;
   localparam logic [2:0] CSR_SLEEP_START = 3'd5;

   // register reset values
   localparam logic [7:0]  RST_BASE_STEP   = 8'd10;
   localparam logic [15:0] RST_FADE_MS     = 16'd1000;
   localparam logic [15:0] RST_SLEEP_TO    = 16'd0;
   localparam logic [2:0]  RST_CHAN_COUNT  = 3'd4;
   localparam logic [3:0]  RST_CHAN_MODES  = 4'hF;
   localparam logic [7:0]  RST_SLEEP_START = 8'd0;

   // duration byte codes
   localparam logic [7:0] DUR_HOLD = 8'h00;
   localparam logic [7:0] DUR_END  = 8'hFF;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] table_addr;
      logic [7:0] table_data;
   } lsfp_req_type;

   typedef struct packed {
      logic [1:0] chan_index;
      logic       is_switch;
      logic [7:0] level;
      logic       last;
   } lsfp_rsp_type;

endpackage

// ===== hw/rtl/lsfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lsfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/led_sequence_fade_player_top.sv =====
// Top level of the LED sequence fade player: sequencer, channel state, shared divider.
// Depends on lsfp_pkg and lsfp_ram.
`timescale 1ns / 1ps

// LED step-sequence player. Table writes, sequence starts, fade requests and
// sleep activation take effect at the edge they are accepted; busy stays low.
// A 1 ms tick raises busy while the sequencer works: it fetches table bytes
// (duration byte, next-sequence byte, one level byte per driven channel,
// each through the table RAM's single registered read port), then walks the
// driven channels, using the shared 8-step restoring divider where a ramp or
// fade needs it, then flushes in a closing state. Updates come out on
// rsp_data with a one-cycle rsp_valid strobe, one word per cycle at most; the
// receiver cannot stall them, and the word with last set closes the tick.
// Results trail their channel by one step since the last flag is only known
// once the channel walk is done, so the closing word is on the ports in the
// first cycle after busy falls. The table has no reset: an entry must be
// written before playback reads it.
module led_sequence_fade_player_top #(
   parameter int CHANNELS    = lsfp_pkg::CHANNELS_DEF,
   parameter int TABLE_DEPTH = lsfp_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  lsfp_pkg::lsfp_req_type            req_data,
   output logic                              rsp_valid,
   output lsfp_pkg::lsfp_rsp_type            rsp_data,
   input  logic                              csr_we,
   input  logic [2:0]                        csr_index,
   input  logic [lsfp_pkg::CSR_WIDTH-1:0]    csr_wdata
);
   import lsfp_pkg::*;

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MAXCH = (CHANNELS < 4) ? CHANNELS : 4;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a word
   localparam logic [2:0] S_DUR  = 3'd1;   // duration byte on RAM output
   localparam logic [2:0] S_NXT  = 3'd2;   // next-sequence byte on RAM output
   localparam logic [2:0] S_LVL  = 3'd3;   // level byte on RAM output
   localparam logic [2:0] S_CH   = 3'd4;   // examine channel
   localparam logic [2:0] S_DIV  = 3'd5;   // divider iterating
   localparam logic [2:0] S_FIN  = 3'd6;   // commit channel, emit
   localparam logic [2:0] S_END  = 3'd7;   // flush final word

   // configuration
   logic [7:0]  base_ff;
   logic [15:0] fade_ms_ff;
   logic [15:0] sleep_to_ff;
   logic [2:0]  ccount_ff;
   logic [3:0]  modes_ff;
   logic [7:0]  sleep_start_ff;

   // playback state
   logic [7:0]  play_pos_ff;
   logic [7:0]  seq_begin_ff;
   logic        playing_ff;
   logic [15:0] step_wait_ff;
   logic [25:0] sleep_cnt_ff;

   // per-channel state
   logic [7:0]  prev_ff [CHANNELS];
   logic [7:0]  cur_ff  [CHANNELS];
   logic [7:0]  tgt_ff  [CHANNELS];
   logic [15:0] rel_ff  [CHANNELS];
   logic [15:0] rlen_ff [CHANNELS];
   logic [16:0] fel_ff  [CHANNELS];

   // sequencer
   logic [2:0]  state_ff;
   logic [2:0]  ch_ff;
   logic [15:0] len_ff;
   logic [7:0]  res_ff;
   logic        div_used_ff;

   // divider
   logic [15:0] rem_ff;
   logic [15:0] den_ff;
   logic [7:0]  numlo_ff;
   logic [7:0]  q_ff;
   logic [2:0]  dcnt_ff;

   // output staging
   logic         pend_valid_ff;
   lsfp_rsp_type pend_ff;
   logic         rsp_valid_ff;
   lsfp_rsp_type rsp_ff;

   // RAM port
   logic          ram_we;
   logic [7:0]    ram_raddr8;
   logic [7:0]    ram_rdata;

   // address mod depth by compare-subtract (quotient stays below 16)
   function automatic logic [AW-1:0] tab_idx(input logic [7:0] a);
      logic [11:0] r;
      r = {4'd0, a};
      for (int k = 3; k >= 0; k--) begin
         if (r >= 12'(TABLE_DEPTH << k)) begin
            r = r - 12'(TABLE_DEPTH << k);
         end
      end
      return r[AW-1:0];
   endfunction

   logic accept;
   assign accept = start && (state_ff == S_IDLE);

   logic [2:0] n_drv;
   assign n_drv = (ccount_ff > 3'(MAXCH)) ? 3'(MAXCH) : ccount_ff;

   logic [2:0] loop_first;
   assign loop_first = (n_drv == 3'd0) ? S_END : S_CH;

   logic [25:0] sleep_load;
   assign sleep_load = 26'({10'd0, sleep_to_ff} * 26'd1000) + 26'd1;

   logic [15:0] len_now;
   assign len_now = 16'(ram_rdata) * 16'(base_ff);

   assign ram_we = accept && (req_data.req_type == REQ_WRITE);

   always_comb begin
      unique case (state_ff)
         S_DUR:   ram_raddr8 = play_pos_ff + 8'd1;
         S_LVL:   ram_raddr8 = play_pos_ff + 8'(ch_ff) + 8'd2;
         default: ram_raddr8 = play_pos_ff;
      endcase
   end

   lsfp_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tab_idx(req_data.table_addr)),
      .wr_data (req_data.table_data),
      .rd_addr (tab_idx(ram_raddr8)),
      .rd_data (ram_rdata)
   );

   // channel datapath for the channel under ch_ff
   logic [CW-1:0] ci;
   logic [7:0]    c_p, c_t, c_cur, diff, cur_new, tgt_n;
   logic [15:0]   c_e, c_l;
   logic [16:0]   c_fer, fe, fel_n;
   logic          c_pwm, fade_on, fade_zero, ramp_div, ramp_up, emit_pwm, emit_now;
   logic [23:0]   num_ramp, num_fade;
   logic [16:0]   rem_try;
   logic [2:0]    ch_next;
   logic          ch_done;

   always_comb begin
      ci        = ch_ff[CW-1:0];
      c_p       = prev_ff[ci];
      c_t       = tgt_ff[ci];
      c_cur     = cur_ff[ci];
      c_e       = rel_ff[ci];
      c_l       = rlen_ff[ci];
      c_fer     = fel_ff[ci];
      c_pwm     = modes_ff[ch_ff[1:0]];
      fade_on   = (c_fer != 17'd0);
      fe        = c_fer - 17'd1;
      fade_zero = (fade_ms_ff == 16'd0) || (fe >= {1'b0, fade_ms_ff});
      ramp_div  = (c_t != c_p) && (c_l != 16'd0) && (c_e < c_l);
      ramp_up   = (c_t > c_p);
      diff      = ramp_up ? (c_t - c_p) : (c_p - c_t);
      num_ramp  = 24'(diff) * 24'(c_e);
      num_fade  = 24'(c_t) * 24'(fade_ms_ff - fe[15:0]);
      if (!div_used_ff) begin
         cur_new = res_ff;
      end else if (fade_on) begin
         cur_new = q_ff;
      end else if (ramp_up) begin
         cur_new = c_p + q_ff;
      end else begin
         cur_new = c_p - q_ff;
      end
      tgt_n = c_t;
      fel_n = c_fer;
      if (fade_on) begin
         if (cur_new == 8'd0) begin
            tgt_n = 8'd0;
            fel_n = 17'd0;
         end else if (c_fer != 17'h1FFFF) begin
            fel_n = c_fer + 17'd1;
         end
      end
      emit_pwm = (c_p != tgt_n) || (fel_n != 17'd0);
      emit_now = c_pwm ? emit_pwm : (c_cur != c_t);
      rem_try  = {rem_ff, numlo_ff[7]};
      ch_next  = ch_ff + 3'd1;
      ch_done  = (ch_next >= n_drv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff        <= RST_BASE_STEP;
         fade_ms_ff     <= RST_FADE_MS;
         sleep_to_ff    <= RST_SLEEP_TO;
         ccount_ff      <= RST_CHAN_COUNT;
         modes_ff       <= RST_CHAN_MODES;
         sleep_start_ff <= RST_SLEEP_START;
         play_pos_ff    <= 8'd0;
         seq_begin_ff   <= 8'd0;
         playing_ff     <= 1'b0;
         step_wait_ff   <= 16'd0;
         sleep_cnt_ff   <= 26'd0;
         for (int i = 0; i < CHANNELS; i++) begin
            prev_ff[i] <= 8'd0;
            cur_ff[i]  <= 8'd0;
            tgt_ff[i]  <= 8'd0;
            rel_ff[i]  <= 16'd0;
            rlen_ff[i] <= 16'd0;
            fel_ff[i]  <= 17'd0;
         end
         state_ff      <= S_IDLE;
         ch_ff         <= 3'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // staged word goes out when the next one is staged or the walk ends
         rsp_valid_ff <= pend_valid_ff &&
                         ((state_ff == S_END) || ((state_ff == S_FIN) && emit_now));

         if (csr_we) begin
            unique case (csr_index)
               CSR_BASE_STEP:   base_ff        <= csr_wdata[7:0];
               CSR_FADE_MS:     fade_ms_ff     <= csr_wdata;
               CSR_SLEEP_TO:    sleep_to_ff    <= csr_wdata;
               CSR_CHAN_COUNT:  ccount_ff      <= csr_wdata[2:0];
               CSR_CHAN_MODES:  modes_ff       <= csr_wdata[3:0];
               CSR_SLEEP_START: sleep_start_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_data.req_type)
                     REQ_START: begin
                        seq_begin_ff <= req_data.table_addr;
                        play_pos_ff  <= req_data.table_addr;
                        step_wait_ff <= 16'd0;
                        playing_ff   <= 1'b1;
                        if (sleep_to_ff != 16'd0) sleep_cnt_ff <= sleep_load;
                     end
                     REQ_FADE: begin
                        for (int i = 0; i < CHANNELS; i++) begin
                           if ((3'(i) < n_drv) && modes_ff[2'(i)] && (fel_ff[i] == 17'd0)) begin
                              fel_ff[i]  <= 17'd1;
                              prev_ff[i] <= cur_ff[i];
                              tgt_ff[i]  <= cur_ff[i];
                           end
                        end
                     end
                     REQ_SLEEP: begin
                        seq_begin_ff <= sleep_start_ff;
                        play_pos_ff  <= sleep_start_ff;
                        step_wait_ff <= 16'd0;
                        playing_ff   <= 1'b1;
                     end
                     REQ_TICK: begin
                        if (sleep_cnt_ff == 26'd1) begin
                           // sleep fires: restart on the sleep sequence, no output
                           sleep_cnt_ff <= (sleep_to_ff != 16'd0) ? sleep_load : 26'd0;
                           seq_begin_ff <= sleep_start_ff;
                           play_pos_ff  <= sleep_start_ff;
                           step_wait_ff <= 16'd0;
                           playing_ff   <= 1'b1;
                        end else begin
                           if (sleep_cnt_ff != 26'd0) sleep_cnt_ff <= sleep_cnt_ff - 26'd1;
                           if (playing_ff) begin
                              ch_ff <= 3'd0;
                              if (step_wait_ff != 16'd0) begin
                                 step_wait_ff <= step_wait_ff - 16'd1;
                                 state_ff     <= loop_first;
                              end else begin
                                 state_ff <= S_DUR;
                              end
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end

            S_DUR: begin
               if (ram_rdata == DUR_END) begin
                  state_ff <= S_NXT;
               end else if (ram_rdata == DUR_HOLD) begin
                  state_ff <= loop_first;
               end else begin
                  len_ff <= len_now;
                  if (n_drv == 3'd0) begin
                     step_wait_ff <= len_now;
                     play_pos_ff  <= play_pos_ff + 8'd1;
                     state_ff     <= S_END;
                  end else begin
                     state_ff <= S_LVL;
                  end
               end
            end

            S_NXT: begin
               if (ram_rdata == seq_begin_ff) begin
                  play_pos_ff <= seq_begin_ff;
                  state_ff    <= loop_first;
               end else begin
                  // jump to another sequence; this tick ends silently
                  seq_begin_ff <= ram_rdata;
                  play_pos_ff  <= ram_rdata;
                  step_wait_ff <= 16'd0;
                  playing_ff   <= 1'b1;
                  if (sleep_to_ff != 16'd0) sleep_cnt_ff <= sleep_load;
                  state_ff <= S_IDLE;
               end
            end

            S_LVL: begin
               tgt_ff[ci] <= ram_rdata;
               if (c_pwm) begin
                  fel_ff[ci]  <= 17'd0;
                  prev_ff[ci] <= c_cur;
                  rlen_ff[ci] <= len_ff;
                  rel_ff[ci]  <= 16'd0;
                  if (len_ff == 16'd0) cur_ff[ci] <= ram_rdata;
               end
               if (ch_done) begin
                  step_wait_ff <= len_ff;
                  play_pos_ff  <= play_pos_ff + 8'(n_drv) + 8'd1;
                  ch_ff        <= 3'd0;
                  state_ff     <= S_CH;
               end else begin
                  ch_ff <= ch_next;
               end
            end

            S_CH: begin
               dcnt_ff <= 3'd0;
               q_ff    <= 8'd0;
               if (c_pwm && fade_on && !fade_zero) begin
                  div_used_ff <= 1'b1;
                  rem_ff      <= num_fade[23:8];
                  numlo_ff    <= num_fade[7:0];
                  den_ff      <= fade_ms_ff;
                  state_ff    <= S_DIV;
               end else if (c_pwm && !fade_on && ramp_div) begin
                  div_used_ff <= 1'b1;
                  rem_ff      <= num_ramp[23:8];
                  numlo_ff    <= num_ramp[7:0];
                  den_ff      <= c_l;
                  state_ff    <= S_DIV;
               end else begin
                  // no division: switch channel, fade at its end, ramp done, or level unchanged
                  div_used_ff <= 1'b0;
                  res_ff      <= (c_pwm && fade_on) ? 8'd0 : ((c_t != c_p) ? c_t : c_cur);
                  state_ff    <= S_FIN;
               end
            end

            S_DIV: begin
               // one restoring step per cycle, quotient fits in 8 bits
               if (rem_try >= {1'b0, den_ff}) begin
                  rem_ff <= 16'(rem_try - {1'b0, den_ff});
                  q_ff   <= {q_ff[6:0], 1'b1};
               end else begin
                  rem_ff <= rem_try[15:0];
                  q_ff   <= {q_ff[6:0], 1'b0};
               end
               numlo_ff <= {numlo_ff[6:0], 1'b0};
               dcnt_ff  <= dcnt_ff + 3'd1;
               if (dcnt_ff == 3'd7) state_ff <= S_FIN;
            end

            S_FIN: begin
               if (c_pwm) begin
                  cur_ff[ci] <= cur_new;
                  tgt_ff[ci] <= tgt_n;
                  fel_ff[ci] <= fel_n;
                  if (c_e != 16'hFFFF) rel_ff[ci] <= c_e + 16'd1;
                  if (emit_pwm && (cur_new == tgt_n)) prev_ff[ci] <= tgt_n;
               end else begin
                  cur_ff[ci] <= c_t;
               end
               if (emit_now) begin
                  if (pend_valid_ff) begin
                     rsp_ff <= pend_ff;
                  end
                  pend_valid_ff      <= 1'b1;
                  pend_ff.chan_index <= ch_ff[1:0];
                  pend_ff.is_switch  <= !c_pwm;
                  pend_ff.level      <= c_pwm ? cur_new : {7'd0, (c_t != 8'd0)};
                  pend_ff.last       <= 1'b0;
               end
               ch_ff    <= ch_next;
               state_ff <= ch_done ? S_END : S_CH;
            end

            S_END: begin
               if (pend_valid_ff) begin
                  rsp_ff        <= '{chan_index: pend_ff.chan_index,
                                     is_switch:  pend_ff.is_switch,
                                     level:      pend_ff.level,
                                     last:       1'b1};
                  pend_valid_ff <= 1'b0;
               end
               state_ff <= S_IDLE;
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word outside a tick");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !rsp_valid)
      else $error("word follows the closing word");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |=> (busy || rsp_valid))
      else $error("tick ended without a closing word");

   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !pend_valid_ff)
      else $error("staged word left behind");
`endif

endmodule
